[rtl/bmp_fb_pkg.sv]
// ----------------------------------------------------------------------------
// bmp_fb_pkg
// Shared types and constants for the BMP pixel array to framebuffer decoder.
// ----------------------------------------------------------------------------
package bmp_fb_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;
   localparam int DIM_REG_W   = 12;
   localparam int ADDR_W      = 19;
   localparam int COLOR_W     = 32;
   localparam int BYTE_W      = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MIRROR_X     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TOP_DOWN     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FOUR_BPP     = 3'd4;

   localparam logic [DIM_REG_W-1:0] RESET_IMAGE_WIDTH  = 12'd800;
   localparam logic [DIM_REG_W-1:0] RESET_IMAGE_HEIGHT = 12'd480;

   typedef struct packed {
      logic [DIM_REG_W-1:0] image_width;
      logic [DIM_REG_W-1:0] image_height;
      logic                 mirror_x;
      logic                 top_down;
      logic                 four_bytes_per_pixel;
   } cfg_type;

endpackage

[rtl/bmp_fb_front.sv]
// ----------------------------------------------------------------------------
// bmp_fb_front
// Takes pixel array bytes, skips row padding, assembles ARGB pixels and
// tracks the image column and row.
// ----------------------------------------------------------------------------
module bmp_fb_front #(
   parameter int CW = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bmp_fb_pkg::cfg_type      cfg,
   input  logic [CW:0]              eff_width,
   input  logic [CW:0]              eff_height,
   input  logic                     byte_valid,
   input  logic [7:0]               byte_data,
   output logic                     pix_valid,
   output logic [31:0]              pix_color,
   output logic [CW-1:0]            pix_col,
   output logic [CW-1:0]            pix_row,
   output logic                     pix_last
);
   import bmp_fb_pkg::*;

   typedef enum logic [1:0] {
      PH_BLUE  = 2'd0,
      PH_GREEN = 2'd1,
      PH_RED   = 2'd2,
      PH_ALPHA = 2'd3
   } phase_type;

   phase_type     phase_ff, phase_in;
   logic [23:0]   accum_ff, accum_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic [1:0]    pad_ff, pad_in;

   logic          done;
   logic [31:0]   color;
   logic          col_end;
   logic          row_end;

   assign col_end = ({1'b0, col_ff} + 1'b1) >= eff_width;
   assign row_end = ({1'b0, row_ff} + 1'b1) >= eff_height;

   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      pad_in   = pad_ff;
      done     = 1'b0;
      color    = {8'd0, accum_ff};
      if (byte_valid) begin
         if (pad_ff != 2'd0) begin
            pad_in = pad_ff - 2'd1;
         end else begin
            unique case (phase_ff)
               PH_BLUE: begin
                  accum_in = {16'd0, byte_data};
                  phase_in = PH_GREEN;
               end
               PH_GREEN: begin
                  accum_in = {accum_ff[23:16], byte_data, accum_ff[7:0]};
                  phase_in = PH_RED;
               end
               PH_RED: begin
                  accum_in = {byte_data, accum_ff[15:0]};
                  if (cfg.four_bytes_per_pixel) begin
                     phase_in = PH_ALPHA;
                  end else begin
                     done  = 1'b1;
                     color = {8'd0, byte_data, accum_ff[15:0]};
                  end
               end
               PH_ALPHA: begin
                  done = 1'b1;
                  if (cfg.four_bytes_per_pixel) begin
                     color = {byte_data, accum_ff};
                  end else begin
                     // depth dropped to 24 bits: take this byte as red
                     accum_in = {byte_data, accum_ff[15:0]};
                     color    = {8'd0, byte_data, accum_ff[15:0]};
                  end
               end
               default: begin
                  phase_in = PH_BLUE;
               end
            endcase
            if (done) begin
               phase_in = PH_BLUE;
               if (col_end) begin
                  // 24-bit rows pad to a word: pad count equals width mod 4
                  pad_in = cfg.four_bytes_per_pixel ? 2'd0 : eff_width[1:0];
                  col_in = '0;
                  row_in = row_end ? '0 : row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
      end
   end

   assign pix_valid = done;
   assign pix_color = color;
   assign pix_col   = col_ff;
   assign pix_row   = row_ff;
   assign pix_last  = col_end && row_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BLUE;
         accum_ff <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         pad_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         pad_ff   <= pad_in;
      end
   end

endmodule

[rtl/bmp_fb_queue.sv]
// ----------------------------------------------------------------------------
// bmp_fb_queue
// Short register queue between the byte front end and the address back end.
// ----------------------------------------------------------------------------
module bmp_fb_queue #(
   parameter int DATA_W = 57
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);
   import bmp_fb_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] mem [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]     count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = count_ff == NW'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/bmp_fb_back.sv]
// ----------------------------------------------------------------------------
// bmp_fb_back
// Mirrors/flips the pixel position, clips to the screen and forms the
// framebuffer word address; two stages, the second is the result register.
// ----------------------------------------------------------------------------
module bmp_fb_back #(
   parameter int CW            = 12,
   parameter int SCREEN_WIDTH  = 800,
   parameter int SCREEN_HEIGHT = 480
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bmp_fb_pkg::cfg_type      cfg,
   input  logic [CW:0]              eff_width,
   input  logic [CW:0]              eff_height,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [31:0]              in_color,
   input  logic [CW-1:0]            in_col,
   input  logic [CW-1:0]            in_row,
   input  logic                     in_last,
   output logic                     out_valid,
   input  logic                     out_pop,
   output logic [bmp_fb_pkg::ADDR_W-1:0] out_address,
   output logic [31:0]              out_color,
   output logic                     out_on_screen,
   output logic                     out_last
);
   import bmp_fb_pkg::*;

   localparam int DW = CW + 1;
   localparam int XW = DW + 1;
   localparam int PW = 2 * DW;

   logic [XW-1:0] x_pos;
   logic [XW-1:0] y_pos;
   logic          on_x;
   logic          on_y;
   logic          a_ready;
   logic          b_ready;
   logic [PW-1:0] full_addr;

   logic          a_valid_ff;
   logic [DW-1:0] a_x_ff;
   logic [DW-1:0] a_y_ff;
   logic          a_on_ff;
   logic [31:0]   a_color_ff;
   logic          a_last_ff;

   logic              b_valid_ff;
   logic [ADDR_W-1:0] b_addr_ff;
   logic [31:0]       b_color_ff;
   logic              b_on_ff;
   logic              b_last_ff;

   // coordinates in two's complement, one bit wider than the dimension
   assign x_pos = cfg.mirror_x ? ({1'b0, eff_width} - XW'(1) - {2'b00, in_col})
                               : {2'b00, in_col};
   assign y_pos = cfg.top_down ? {2'b00, in_row}
                               : ({1'b0, eff_height} - XW'(1) - {2'b00, in_row});
   assign on_x = !x_pos[XW-1] && (x_pos < XW'(SCREEN_WIDTH));
   assign on_y = !y_pos[XW-1] && (y_pos < XW'(SCREEN_HEIGHT));

   assign b_ready  = !b_valid_ff || out_pop;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign full_addr = PW'(a_y_ff) * PW'(SCREEN_WIDTH) + PW'(a_x_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
      if (a_ready && in_valid) begin
         a_x_ff     <= x_pos[DW-1:0];
         a_y_ff     <= y_pos[DW-1:0];
         a_on_ff    <= on_x && on_y;
         a_color_ff <= in_color;
         a_last_ff  <= in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_ready && a_valid_ff) begin
         b_addr_ff  <= a_on_ff ? full_addr[ADDR_W-1:0] : '0;
         b_color_ff <= a_color_ff;
         b_on_ff    <= a_on_ff;
         b_last_ff  <= a_last_ff;
      end
   end

   assign out_valid     = b_valid_ff;
   assign out_address   = b_addr_ff;
   assign out_color     = b_color_ff;
   assign out_on_screen = b_on_ff;
   assign out_last      = b_last_ff;

endmodule

[rtl/bmp_pixel_to_framebuffer.sv]
// ----------------------------------------------------------------------------
// bmp_pixel_to_framebuffer
// Decodes a 24/32-bit BMP pixel array byte stream into framebuffer writes.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req_      in         push / full        pixel_byte
//  rsp_      out        empty / pop        fb_address, argb_color,
//                                          on_screen, last_pixel
//  csr_      in         write_en           index, wdata
//
//  One byte is taken every cycle while req_full is low; a result leaves at
//  most once per three bytes. A pixel's result is queued at the edge that
//  takes its last byte, then passes the coordinate stage and then the
//  address multiply stage before it shows on rsp_.
//  req_full rises only when the result side has stalled long enough to fill
//  the queue. Synchronous reset restores the registers to 800 x 480, 24-bit,
//  bottom-up, and clears all counters; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bmp_pixel_to_framebuffer #(
   parameter int SCREEN_WIDTH  = 800,
   parameter int SCREEN_HEIGHT = 480,
   parameter int MAX_DIMENSION = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [bmp_fb_pkg::BYTE_W-1:0]       req_pixel_byte,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [bmp_fb_pkg::ADDR_W-1:0]       rsp_fb_address,
   output logic [bmp_fb_pkg::COLOR_W-1:0]      rsp_argb_color,
   output logic                                rsp_on_screen,
   output logic                                rsp_last_pixel,
   input  logic                                csr_write_en,
   input  logic [bmp_fb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bmp_fb_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bmp_fb_pkg::*;

   localparam int MAX_BITS = $clog2(MAX_DIMENSION);
   localparam int CW       = (MAX_BITS > DIM_REG_W) ? MAX_BITS : DIM_REG_W;
   localparam int DW       = CW + 1;
   localparam int QW       = 1 + 2 * CW + COLOR_W;

   cfg_type       cfg_ff;
   logic [DW-1:0] eff_width;
   logic [DW-1:0] eff_height;

   logic          byte_accept;
   logic          pix_valid;
   logic [31:0]   pix_color;
   logic [CW-1:0] pix_col;
   logic [CW-1:0] pix_row;
   logic          pix_last;

   logic [QW-1:0] q_push_data;
   logic [QW-1:0] q_pop_data;
   logic          q_full;
   logic          q_empty;
   logic          back_ready;
   logic          back_out_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width          <= RESET_IMAGE_WIDTH;
         cfg_ff.image_height         <= RESET_IMAGE_HEIGHT;
         cfg_ff.mirror_x             <= 1'b0;
         cfg_ff.top_down             <= 1'b0;
         cfg_ff.four_bytes_per_pixel <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  cfg_ff.image_width          <= csr_wdata[DIM_REG_W-1:0];
            REG_IMAGE_HEIGHT: cfg_ff.image_height         <= csr_wdata[DIM_REG_W-1:0];
            REG_MIRROR_X:     cfg_ff.mirror_x             <= csr_wdata[0];
            REG_TOP_DOWN:     cfg_ff.top_down             <= csr_wdata[0];
            REG_FOUR_BPP:     cfg_ff.four_bytes_per_pixel <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // a zero dimension stands for the maximum
   assign eff_width  = (cfg_ff.image_width == '0) ? DW'(MAX_DIMENSION)
                                                  : DW'(cfg_ff.image_width);
   assign eff_height = (cfg_ff.image_height == '0) ? DW'(MAX_DIMENSION)
                                                   : DW'(cfg_ff.image_height);

   assign req_full    = q_full;
   assign byte_accept = req_push && !q_full;

   bmp_fb_front #(
      .CW (CW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .eff_width  (eff_width),
      .eff_height (eff_height),
      .byte_valid (byte_accept),
      .byte_data  (req_pixel_byte),
      .pix_valid  (pix_valid),
      .pix_color  (pix_color),
      .pix_col    (pix_col),
      .pix_row    (pix_row),
      .pix_last   (pix_last)
   );

   assign q_push_data = {pix_last, pix_row, pix_col, pix_color};

   bmp_fb_queue #(
      .DATA_W (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (pix_valid),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (back_ready),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   bmp_fb_back #(
      .CW            (CW),
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .eff_width     (eff_width),
      .eff_height    (eff_height),
      .in_valid      (!q_empty),
      .in_ready      (back_ready),
      .in_color      (q_pop_data[COLOR_W-1:0]),
      .in_col        (q_pop_data[COLOR_W+CW-1:COLOR_W]),
      .in_row        (q_pop_data[COLOR_W+2*CW-1:COLOR_W+CW]),
      .in_last       (q_pop_data[QW-1]),
      .out_valid     (back_out_valid),
      .out_pop       (rsp_pop),
      .out_address   (rsp_fb_address),
      .out_color     (rsp_argb_color),
      .out_on_screen (rsp_on_screen),
      .out_last      (rsp_last_pixel)
   );

   assign rsp_empty = !back_out_valid;

endmodule

[test/bmp_fb_checker.sv]
// ----------------------------------------------------------------------------
// bmp_fb_checker
// Watches the byte, framebuffer-write and register ports of the BMP decoder.
// Keeps its own copy of the registers and of the pixel assembly, row padding
// and column/row counters. From each accepted byte it predicts the framebuffer
// write, if any, and checks every popped write against the oldest prediction.
// ----------------------------------------------------------------------------
module bmp_fb_checker #(
   parameter int SCREEN_WIDTH  = 800,
   parameter int SCREEN_HEIGHT = 480,
   parameter int MAX_DIMENSION = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  logic                                req_full,
   input  logic [bmp_fb_pkg::BYTE_W-1:0]       req_pixel_byte,
   input  logic                                rsp_empty,
   input  logic                                rsp_pop,
   input  logic [bmp_fb_pkg::ADDR_W-1:0]       rsp_fb_address,
   input  logic [bmp_fb_pkg::COLOR_W-1:0]      rsp_argb_color,
   input  logic                                rsp_on_screen,
   input  logic                                rsp_last_pixel,
   input  logic                                csr_write_en,
   input  logic [bmp_fb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bmp_fb_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                  mismatch_total,
   output int                                  writes_due_count,
   output int                                  bytes_decoded,
   output int                                  writes_checked,
   output int                                  offscreen_writes,
   output int                                  images_ended
);

   import bmp_fb_pkg::*;

   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [COLOR_W-1:0] argb;
      logic               on;
      logic               last;
   } fb_write_type;

   fb_write_type writes_due[$];

   cfg_type              settings;
   logic [1:0]           phase;
   logic [23:0]          accum;
   logic [DIM_REG_W-1:0] col;
   logic [DIM_REG_W-1:0] row;
   logic [1:0]           pad_left;

   int mismatches = 0;
   int n_bytes    = 0;
   int n_writes   = 0;
   int n_offscr   = 0;
   int n_images   = 0;

   task automatic apply_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      case (idx)
         REG_IMAGE_WIDTH:  settings.image_width = val[DIM_REG_W-1:0];
         REG_IMAGE_HEIGHT: settings.image_height = val[DIM_REG_W-1:0];
         REG_MIRROR_X:     settings.mirror_x = val[0];
         REG_TOP_DOWN:     settings.top_down = val[0];
         REG_FOUR_BPP:     settings.four_bytes_per_pixel = val[0];
         default: ;
      endcase
   endtask

   // Advance the decoder by one byte; queue a write when a pixel completes.
   task automatic decode_byte(input logic [BYTE_W-1:0] b);
      logic         done;
      logic [31:0]  addr_full;
      fb_write_type wr;
      int           w, h, c, r, x, y, pad;
      done = 1'b0;
      wr = '0;
      if (pad_left != 2'd0) begin
         pad_left = pad_left - 2'd1;
      end else begin
         case (phase)
            2'd0: begin
               accum = {16'd0, b};
               phase = 2'd1;
            end
            2'd1: begin
               accum = {8'd0, b, accum[7:0]};
               phase = 2'd2;
            end
            2'd2: begin
               accum = {b, accum[15:0]};
               if (settings.four_bytes_per_pixel) begin
                  phase = 2'd3;
               end else begin
                  wr.argb = {8'd0, accum};
                  done = 1'b1;
               end
            end
            default: begin
               // depth dropped to 24-bit here: this byte is red
               if (settings.four_bytes_per_pixel) begin
                  wr.argb = {b, accum};
               end else begin
                  accum = {b, accum[15:0]};
                  wr.argb = {8'd0, accum};
               end
               done = 1'b1;
            end
         endcase
      end
      if (done) begin
         phase = 2'd0;
         w = (settings.image_width == '0) ? MAX_DIMENSION : settings.image_width;
         h = (settings.image_height == '0) ? MAX_DIMENSION : settings.image_height;
         c = col;
         r = row;
         x = settings.mirror_x ? (w - 1 - c) : c;
         y = settings.top_down ? r : (h - 1 - r);
         wr.on = (x >= 0) && (x < SCREEN_WIDTH) && (y >= 0) && (y < SCREEN_HEIGHT);
         if (wr.on) begin
            addr_full = y * SCREEN_WIDTH + x;
            wr.addr = addr_full[ADDR_W-1:0];
         end
         wr.last = (c + 1 >= w) && (r + 1 >= h);
         if (c + 1 >= w) begin
            pad = (4 - ((w * (settings.four_bytes_per_pixel ? 4 : 3)) & 3)) & 3;
            pad_left = pad[1:0];
            col = '0;
            row = (r + 1 >= h) ? '0 : row + 1'b1;
         end else begin
            col = col + 1'b1;
         end
         writes_due.push_back(wr);
      end
   endtask

   task automatic report(input string what, input fb_write_type want);
      if (mismatches < 10) begin
         $display("[%0t] %s: expected addr %0d argb %08h on %0b last %0b", $realtime,
                  what, want.addr, want.argb, want.on, want.last);
         $display("           got      addr %0d argb %08h on %0b last %0b",
                  rsp_fb_address, rsp_argb_color, rsp_on_screen, rsp_last_pixel);
      end
      mismatches++;
   endtask

   task automatic check_write();
      fb_write_type want;
      if (writes_due.size() == 0) begin
         report("write with nothing due", '0);
      end else begin
         want = writes_due.pop_front();
         if (rsp_fb_address !== want.addr || rsp_argb_color !== want.argb ||
             rsp_on_screen !== want.on || rsp_last_pixel !== want.last)
            report("framebuffer write differs", want);
         if (!want.on) n_offscr++;
         if (want.last) n_images++;
      end
      n_writes++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         settings.image_width = RESET_IMAGE_WIDTH;
         settings.image_height = RESET_IMAGE_HEIGHT;
         settings.mirror_x = 1'b0;
         settings.top_down = 1'b0;
         settings.four_bytes_per_pixel = 1'b0;
         phase = 2'd0;
         accum = '0;
         col = '0;
         row = '0;
         pad_left = 2'd0;
         writes_due.delete();
      end else begin
         if (csr_write_en)
            apply_register(csr_index, csr_wdata);
         // check before decoding so a write popped this edge never meets
         // the prediction made at the same edge
         if (rsp_pop && !rsp_empty)
            check_write();
         if (req_push && !req_full) begin
            decode_byte(req_pixel_byte);
            n_bytes++;
         end
      end
      mismatch_total <= mismatches;
      writes_due_count <= writes_due.size();
      bytes_decoded <= n_bytes;
      writes_checked <= n_writes;
      offscreen_writes <= n_offscr;
      images_ended <= n_images;
   end

endmodule

[test/tb_bmp_pixel_to_framebuffer.sv]
// ----------------------------------------------------------------------------
// tb_bmp_pixel_to_framebuffer
// Streams BMP pixel-array bytes into the decoder under changing image sizes,
// depths and orientations, with random gaps on the byte side and random
// stalls on the write side. Prediction and checking live in bmp_fb_checker.
// ----------------------------------------------------------------------------
module tb_bmp_pixel_to_framebuffer;

   import bmp_fb_pkg::*;

   localparam int SCREEN_W      = 800;
   localparam int SCREEN_H      = 480;
   localparam int MAX_DIM       = 4096;
   localparam int TARGET_BYTES  = 1450;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 3000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [BYTE_W-1:0]      req_pixel_byte = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [ADDR_W-1:0]      rsp_fb_address;
   logic [COLOR_W-1:0]     rsp_argb_color;
   logic                   rsp_on_screen;
   logic                   rsp_last_pixel;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int mismatch_total, writes_due_count, bytes_decoded;
   int writes_checked, offscreen_writes, images_ended;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int bytes_sent     = 0;
   int settings_used  = 0;
   int quiet_cycles   = 0;

   always #4 clock = ~clock;

   bmp_pixel_to_framebuffer #(
      .SCREEN_WIDTH  (SCREEN_W),
      .SCREEN_HEIGHT (SCREEN_H),
      .MAX_DIMENSION (MAX_DIM)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_pixel_byte (req_pixel_byte),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_fb_address (rsp_fb_address),
      .rsp_argb_color (rsp_argb_color),
      .rsp_on_screen  (rsp_on_screen),
      .rsp_last_pixel (rsp_last_pixel),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   bmp_fb_checker #(
      .SCREEN_WIDTH  (SCREEN_W),
      .SCREEN_HEIGHT (SCREEN_H),
      .MAX_DIMENSION (MAX_DIM)
   ) write_check (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_pixel_byte   (req_pixel_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_fb_address   (rsp_fb_address),
      .rsp_argb_color   (rsp_argb_color),
      .rsp_on_screen    (rsp_on_screen),
      .rsp_last_pixel   (rsp_last_pixel),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_total   (mismatch_total),
      .writes_due_count (writes_due_count),
      .bytes_decoded    (bytes_decoded),
      .writes_checked   (writes_checked),
      .offscreen_writes (offscreen_writes),
      .images_ended     (images_ended)
   );

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_write_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("no word moved for %0d cycles", STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic cfg_type make_settings(input int w, input int h, input logic mx,
                                             input logic td, input logic four);
      cfg_type c;
      c.image_width = DIM_REG_W'(w);
      c.image_height = DIM_REG_W'(h);
      c.mirror_x = mx;
      c.top_down = td;
      c.four_bytes_per_pixel = four;
      return c;
   endfunction

   // Mostly tiny images; now and then a boundary size or the zero encoding.
   function automatic int pick_dim();
      case ($urandom_range(19))
         0: return 0;
         1: return 4095;
         2: return 800;
         3: return 801;
         4: return 480;
         5: return 481;
         6: return $urandom_range(4095);
         default: return $urandom_range(1, 8);
      endcase
   endfunction

   function automatic int image_bytes(input cfg_type c);
      int row_bytes;
      row_bytes = c.image_width * (c.four_bytes_per_pixel ? 4 : 3);
      return c.image_height * (row_bytes + ((4 - (row_bytes & 3)) & 3));
   endfunction

   task automatic set_traffic(input int mix);
      case (mix)
         0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
         1: begin send_idle_pct <= 79; recv_stall_pct <= 0;  end
         2: begin send_idle_pct <= 0;  recv_stall_pct <= 79; end
         default: begin send_idle_pct <= 13; recv_stall_pct <= 13; end
      endcase
   endtask

   task automatic write_settings(input cfg_type c);
      logic [CSR_INDEX_W-1:0] idx [5];
      logic [CSR_DATA_W-1:0]  val [5];
      idx[0] = REG_IMAGE_WIDTH;  val[0] = c.image_width;
      idx[1] = REG_IMAGE_HEIGHT; val[1] = c.image_height;
      idx[2] = REG_MIRROR_X;     val[2] = CSR_DATA_W'(c.mirror_x);
      idx[3] = REG_TOP_DOWN;     val[3] = CSR_DATA_W'(c.top_down);
      idx[4] = REG_FOUR_BPP;     val[4] = CSR_DATA_W'(c.four_bytes_per_pixel);
      for (int i = 0; i < 5; i++) begin
         csr_write_en <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_pixel_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      bytes_sent++;
   endtask

   // Drop push, wait for every predicted write, then let the pipe empty.
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (writes_due_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      cfg_type c;
      int      n;
      int      mix;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: bottom-up 800 x 480, first pixel on the bottom-left
      repeat (3) send_byte(8'h00);
      repeat (3) send_byte(8'hff);
      settle();

      // mirrored 32-bit; the row goes on from column 2, so the pixel lands two words before the last framebuffer word
      write_settings(make_settings(800, 480, 1'b1, 1'b0, 1'b1));
      repeat (4) send_byte(8'hff);
      settle();

      // single-pixel image: last pixel, one pad byte, then a fresh image
      write_settings(make_settings(1, 1, 1'b0, 1'b1, 1'b0));
      send_byte(8'h12); send_byte(8'h34); send_byte(8'h56);
      send_byte(8'haa);
      send_byte(8'h80); send_byte(8'h01); send_byte(8'hfe);
      settle();

      // zero size means the maximum; stop at the alpha byte, then go 24-bit
      write_settings(make_settings(0, 0, 1'b1, 1'b0, 1'b1));
      send_byte(8'h01); send_byte(8'h02); send_byte(8'h04); send_byte(8'h08);
      send_byte(8'h10); send_byte(8'h20); send_byte(8'h40);
      settle();
      write_settings(make_settings(801, 481, 1'b1, 1'b0, 1'b0));
      send_byte(8'h7f);
      settle();

      mix = 0;
      while (bytes_sent < TARGET_BYTES) begin
         c = make_settings(pick_dim(), pick_dim(), 1'($urandom_range(1)),
                           1'($urandom_range(1)), 1'($urandom_range(1)));
         set_traffic(mix % 4);
         write_settings(c);
         if ($urandom_range(3) != 0 && c.image_width >= 1 && c.image_width <= 8 &&
             c.image_height >= 1 && c.image_height <= 8)
            n = image_bytes(c) * $urandom_range(1, 2);
         else
            n = $urandom_range(1, 40);
         // keep the total close to the target
         if (n > TARGET_BYTES - bytes_sent)
            n = TARGET_BYTES - bytes_sent;
         repeat (n) send_byte(BYTE_W'($urandom_range(255)));
         settle();
         mix++;
      end

      settle();
      $display("covered %0d bytes under %0d register settings and four traffic mixes",
               bytes_decoded, settings_used);
      $display("checked %0d pixel writes: %0d off screen, %0d image ends",
               writes_checked, offscreen_writes, images_ended);
      if (mismatch_total == 0 && writes_due_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
